### rtl/event_flag_group_with_waiters_defines.svh
// Assertion macros shared by the event flag group RTL.
// No dependencies; the including module must declare clk_i and rst_ni.
`ifndef EVENT_FLAG_GROUP_WITH_WAITERS_DEFINES_SVH
`define EVENT_FLAG_GROUP_WITH_WAITERS_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define EFG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset
`define EFG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/efg_pkg.sv
// Package for the event flag group: field widths, command/result codes,
// state encoding and parameter defaults. No dependencies.
package efg_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned MAX_WAITERS_DEF = 8;
  localparam int unsigned FLAG_BITS_DEF   = 32;

  // op_flags bit positions
  localparam int unsigned OP_AND = 0;
  localparam int unsigned OP_OR  = 1;
  localparam int unsigned OP_CLR = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_DETACH = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 2'd0,
    KIND_WAKE = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_CONFLICT = 3'd1,
    ST_NO_MODE  = 3'd2,
    ST_NOT_MET  = 3'd3,
    ST_QUEUED   = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

endpackage

### rtl/efg_waiter_mem.sv
// Waiter table storage: one write port, one read port, registered read data.
// Standalone; sized by the top level.
module efg_waiter_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 43,
  parameter int unsigned AW    = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/event_flag_group_with_waiters.sv
// Event flag group with an ordered waiter table: top level.
// Depends on efg_pkg, efg_waiter_mem and event_flag_group_with_waiters_defines.svh.
//
// Usage:
//   Commands go in on start with cmd, task_id, event_mask, op_flags and
//   may_wait; a command is taken at a clock edge with start high and busy low.
//   Results come out on strobe_o with kind, status, woken_task,
//   matched_events and last, one per cycle, each valid for exactly one cycle;
//   last_o marks the final result of a command. The receiver cannot stall.
// Timing:
//   A read gives its single response in the cycle after the transfer and
//   leaves busy low, so reads may follow one another every cycle.
//   A write or detach holds busy high after the transfer while the queued
//   waiters in the table are walked one entry per cycle through the table
//   memory's single read port, and then through the done state. Each woken
//   waiter gives a wake notice as it is walked; the done result appears in
//   the cycle after the done state.
//   An unused command code is taken and dropped with no result.
// Reset:
//   Asynchronous, active low. Clears the flag word and empties the table;
//   table entries are never read before being written, so no clearing pass.
`include "event_flag_group_with_waiters_defines.svh"

module event_flag_group_with_waiters #(
  parameter int unsigned MAX_WAITERS = efg_pkg::MAX_WAITERS_DEF,
  parameter int unsigned FLAG_BITS   = efg_pkg::FLAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [efg_pkg::CMD_W-1:0]     cmd_i,
  input  logic [efg_pkg::TASK_W-1:0]    task_id_i,
  input  logic [efg_pkg::MASK_W-1:0]    event_mask_i,
  input  logic [efg_pkg::OP_W-1:0]      op_flags_i,
  input  logic                          may_wait_i,
  output logic                          strobe_o,
  output logic [efg_pkg::KIND_W-1:0]    kind_o,
  output logic [efg_pkg::STATUS_W-1:0]  status_o,
  output logic [efg_pkg::TASK_W-1:0]    woken_task_o,
  output logic [efg_pkg::MASK_W-1:0]    matched_events_o,
  output logic                          last_o
);

  import efg_pkg::*;

  // Flag bits beyond the mask port can never be set
  localparam int unsigned FW = (FLAG_BITS < MASK_W) ? FLAG_BITS : MASK_W;
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned EW = TASK_W + FW + OP_W;

  state_e          state_q, state_d;
  logic [FW-1:0]   flag_q, flag_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   keep_q, keep_d;
  logic            pend_q, pend_d;
  logic            detach_q, detach_d;

  logic            res_vld_q, res_vld_d;
  kind_e           res_kind_q, res_kind_d;
  status_e         res_status_q, res_status_d;
  logic [TASK_W-1:0] res_task_q, res_task_d;
  logic [MASK_W-1:0] res_match_q, res_match_d;
  logic            res_last_q, res_last_d;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  logic [EW-1:0]   mem_wdata, mem_rdata;

  // Incoming request
  cmd_e            cmd;
  logic [FW-1:0]   req_mask, req_hit;
  logic            req_ok, table_full;

  // Entry under test during a walk
  logic [TASK_W-1:0] ent_task;
  logic [FW-1:0]   ent_mask, ent_hit;
  logic [OP_W-1:0] ent_mode;
  logic            ent_woke;

  assign busy  = (state_q != S_IDLE);
  assign cmd   = cmd_e'(cmd_i);

  assign req_mask   = event_mask_i[FW-1:0];
  assign req_hit    = flag_q & req_mask;
  assign req_ok     = op_flags_i[OP_AND] ? (req_hit == req_mask) : (|req_hit);
  assign table_full = (count_q == CW'(MAX_WAITERS));

  assign ent_task = mem_rdata[TASK_W-1:0];
  assign ent_mask = mem_rdata[TASK_W +: FW];
  assign ent_mode = mem_rdata[TASK_W + FW +: OP_W];
  assign ent_hit  = flag_q & ent_mask;
  assign ent_woke = ent_mode[OP_AND] ? (ent_hit == ent_mask)
                                     : (ent_mode[OP_OR] && (|ent_hit));

  efg_waiter_mem #(
    .DEPTH (MAX_WAITERS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_waiter_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start && (cmd == CMD_WRITE || cmd == CMD_DETACH)) begin
          state_d = (count_q != '0) ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (idx_q >= count_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory access and results
  always_comb begin
    flag_d       = flag_q;
    count_d      = count_q;
    idx_d        = idx_q;
    keep_d       = keep_q;
    pend_d       = 1'b0;
    detach_d     = detach_q;
    mem_we       = 1'b0;
    mem_waddr    = keep_q[IW-1:0];
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = idx_q[IW-1:0];
    res_vld_d    = 1'b0;
    res_kind_d   = res_kind_q;
    res_status_d = res_status_q;
    res_task_d   = res_task_q;
    res_match_d  = res_match_q;
    res_last_d   = res_last_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_READ: begin
              res_vld_d  = 1'b1;
              res_kind_d = KIND_READ;
              res_task_d = task_id_i;
              res_last_d = 1'b1;
              if (op_flags_i[OP_AND] && op_flags_i[OP_OR]) begin
                res_status_d = ST_CONFLICT;
                res_match_d  = '0;
              end else if (!op_flags_i[OP_AND] && !op_flags_i[OP_OR]) begin
                res_status_d = ST_NO_MODE;
                res_match_d  = '0;
              end else begin
                res_match_d = MASK_W'(req_hit);
                if (req_ok) begin
                  res_status_d = ST_OK;
                  if (op_flags_i[OP_CLR]) begin
                    flag_d = flag_q & ~req_hit;
                  end
                end else if (!may_wait_i) begin
                  res_status_d = ST_NOT_MET;
                end else if (table_full) begin
                  res_status_d = ST_FULL;
                end else begin
                  // Append at the tail of the table
                  res_status_d = ST_QUEUED;
                  mem_we       = 1'b1;
                  mem_waddr    = count_q[IW-1:0];
                  mem_wdata    = {op_flags_i, req_mask, task_id_i};
                  count_d      = count_q + CW'(1);
                end
              end
            end
            CMD_WRITE, CMD_DETACH: begin
              detach_d = (cmd == CMD_DETACH);
              if (cmd == CMD_WRITE) begin
                flag_d = flag_q | req_mask;
              end
              keep_d = '0;
              if (count_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = CW'(1);
                pend_d    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (pend_q) begin
          if (detach_q || ent_woke) begin
            res_vld_d    = 1'b1;
            res_kind_d   = KIND_WAKE;
            res_status_d = ST_OK;
            res_task_d   = ent_task;
            res_match_d  = MASK_W'(ent_hit);
            res_last_d   = 1'b0;
            if (!detach_q && ent_mode[OP_CLR]) begin
              flag_d = flag_q & ~ent_hit;
            end
          end else begin
            // Compact: move the survivor down to the next free slot
            mem_we    = 1'b1;
            mem_waddr = keep_q[IW-1:0];
            mem_wdata = mem_rdata;
            keep_d    = keep_q + CW'(1);
          end
        end
        if (idx_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
          pend_d    = 1'b1;
        end
      end
      S_DONE: begin
        res_vld_d    = 1'b1;
        res_kind_d   = KIND_DONE;
        res_status_d = ST_OK;
        res_task_d   = '0;
        res_last_d   = 1'b1;
        if (detach_q) begin
          res_match_d = '0;
          flag_d      = '0;
          count_d     = '0;
        end else begin
          res_match_d = MASK_W'(flag_q);
          count_d     = keep_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      flag_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      keep_q    <= '0;
      pend_q    <= 1'b0;
      detach_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      flag_q    <= flag_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      keep_q    <= keep_d;
      pend_q    <= pend_d;
      detach_q  <= detach_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    res_status_q <= res_status_d;
    res_task_q   <= res_task_d;
    res_match_q  <= res_match_d;
    res_last_q   <= res_last_d;
  end

  assign strobe_o         = res_vld_q;
  assign kind_o           = res_kind_q;
  assign status_o         = res_status_q;
  assign woken_task_o     = res_task_q;
  assign matched_events_o = res_match_q;
  assign last_o           = res_last_q;

  `EFG_ASSERT(a_count_bound, count_q <= CW'(MAX_WAITERS), "waiter count overflow")
  `EFG_ASSERT(a_no_rw_clash, !(mem_we && mem_re) || (mem_waddr != mem_raddr), "port clash")
  `EFG_ASSERT(a_keep_behind, (state_q != S_WALK) || (keep_q < idx_q), "compaction overtook read")
  `EFG_ASSERT_NEXT(a_done_res, state_q == S_DONE, strobe_o && kind_o == KIND_DONE && last_o, "no done")

endmodule
